// ----- hw/rtl/tsd_pkg.sv -----
// Package for the depth-first topological sort block.
// Holds payload structs, codes, controller states and the command/status structs.
// No dependencies.
package tsd_pkg;

  localparam int unsigned MaxJobsDefault  = 64;
  localparam int unsigned MaxEdgesDefault = 256;
  localparam int unsigned JobW = 6;

  typedef enum logic [1:0] {
    FuncDeclare = 2'd0,
    FuncEdge    = 2'd1,
    FuncRun     = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StOrdered  = 2'd0,
    StCycle    = 2'd1,
    StEmpty    = 2'd2,
    StOverflow = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]      func;
    logic [JobW-1:0] job_index;
    logic [JobW-1:0] prereq_index;
  } in_word_t;

  typedef struct packed {
    logic [JobW-1:0] job_out;
    logic [1:0]      status;
    logic            last;
  } out_word_t;

  typedef enum logic [3:0] {
    CtlIdle,
    CtlRoot,
    CtlRootWait,
    CtlTop,
    CtlScan,
    CtlEdgeWait,
    CtlChild,
    CtlEmit,
    CtlStatus,
    CtlClear
  } ctl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // apply a load word
    logic run_start;   // latch run, reset walk pointers
    logic root_rd;     // read node_order[r-1]
    logic root_take;   // decrement r
    logic push_root;
    logic top_rd;      // read stack top
    logic scan_rd;     // read edge at e
    logic scan_step;   // evaluate edge read
    logic child_eval;  // evaluate prereq
    logic emit_rd;     // read order_buffer at out pointer
    logic emit_step;   // advance out pointer
    logic clear_step;  // clear one mark entry
    logic clear_done;  // clear counts
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic r_zero;
    logic root_done;   // root already done
    logic sp_zero;
    logic edge_end;    // e reached edge_count
    logic edge_match;
    logic child_done;
    logic child_cycle;
    logic emit_last;
    logic clear_last;
    logic overflow;
    logic empty;
    logic n_zero;
  } stat_t;

endpackage

// ----- hw/rtl/topological_sort_dfs.sv -----
// Top level of the depth-first topological sort block.
// Depends on tsd_pkg, tsd_ctrl and tsd_datapath.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries in_word_i (func, job_index,
//   prereq_index). Declare and edge words are taken one per cycle. A run word
//   starts the depth-first walk; no further word is taken until the run has
//   handed its results to the output register and the marks are cleared.
//   Output channel out_valid_o/out_ready_i carries out_word_o (job_out,
//   status, last). A run gives one status word, or one word per job with last
//   set on the final one.
//   A run steps through Root and RootWait per node list entry tried as a root,
//   Top per visit of the stack top, Scan and EdgeWait per edge scanned (a node
//   resumes from its saved edge), Child per matching edge, then Root and Emit
//   per emitted job or Status for a status word, then Clear per mark entry.
//   The walk is bound by the single-port edge table scan.
//   Reset clears all counts, marks and the output valid, status and last bits.
//   A stalled receiver holds the output register and the emit sequence
//   simply waits.
module topological_sort_dfs #(
  parameter int unsigned MaxJobs  = tsd_pkg::MaxJobsDefault,
  parameter int unsigned MaxEdges = tsd_pkg::MaxEdgesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tsd_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsd_pkg::out_word_t  out_word_o
);
  tsd_pkg::cmd_t  cmd;
  tsd_pkg::stat_t stat;
  logic [tsd_pkg::JobW-1:0] emit_job;
  logic [tsd_pkg::JobW-1:0] job_q;
  logic [1:0] st;
  logic       lst, from_buf;

  tsd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .in_func_i(in_word_i.func),
    .stat_i(stat), .cmd_o(cmd),
    .out_valid_o, .out_ready_i,
    .out_status_o(st), .out_last_o(lst), .out_from_buf_o(from_buf)
  );

  tsd_datapath #(.MaxJobs(MaxJobs), .MaxEdges(MaxEdges)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .in_i(in_word_i),
    .stat_o(stat), .emit_job_o(emit_job)
  );

  // output job register, loaded with the emitted word
  always_ff @(posedge clk_i) begin
    if (cmd.emit_step) job_q <= emit_job;
  end

  assign out_word_o.job_out = from_buf ? job_q : '0;
  assign out_word_o.status  = st;
  assign out_word_o.last    = lst;

endmodule

// ----- hw/rtl/tsd_datapath.sv -----
// Datapath of the topological sort: graph memories, marks, walk stack, order buffer.
// Depends on tsd_pkg; driven by tsd_ctrl through cmd_t, reports through stat_t.
module tsd_datapath #(
  parameter int unsigned MaxJobs  = tsd_pkg::MaxJobsDefault,
  parameter int unsigned MaxEdges = tsd_pkg::MaxEdgesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsd_pkg::cmd_t       cmd_i,
  input  tsd_pkg::in_word_t   in_i,
  output tsd_pkg::stat_t      stat_o,
  output logic [tsd_pkg::JobW-1:0] emit_job_o
);
  localparam int unsigned JW = tsd_pkg::JobW;
  localparam int unsigned NW = $clog2(MaxJobs + 1);
  localparam int unsigned JA = $clog2(MaxJobs);
  localparam int unsigned EW = $clog2(MaxEdges + 1);
  localparam int unsigned EA = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;

  // memories
  logic [JW-1:0] node_mem [MaxJobs];
  logic [JW-1:0] need_mem [MaxEdges];
  logic [JW-1:0] pre_mem  [MaxEdges];
  logic [JW-1:0] snode_mem [MaxJobs];
  logic [EW-1:0] sedge_mem [MaxJobs];
  logic [JW-1:0] ord_mem  [MaxJobs];

  logic [MaxJobs-1:0] present_q, done_q, onpath_q;
  logic [NW-1:0] node_cnt_q, r_q, sp_q, n_q, op_q;
  logic [EW-1:0] edge_cnt_q, e_q;
  logic          ovf_q;
  logic [JW-1:0] root_q, u_q, need_q, pre_q, ord_q;
  logic [JA-1:0] clr_q;

  // load decode
  logic job_ok, pre_ok, add_job, add_pre, is_edge;
  logic [JA-1:0] job_a, pre_a;
  assign job_a  = in_i.job_index[JA-1:0];
  assign pre_a  = in_i.prereq_index[JA-1:0];
  assign is_edge = (in_i.func == tsd_pkg::FuncEdge);
  assign job_ok = ({1'b0, in_i.job_index} < (JW+1)'(MaxJobs));
  assign pre_ok = ({1'b0, in_i.prereq_index} < (JW+1)'(MaxJobs));
  always_comb begin
    add_job = 1'b0;
    add_pre = 1'b0;
    if (in_i.func == tsd_pkg::FuncDeclare) begin
      add_job = job_ok && !present_q[job_a];
    end else if (is_edge && job_ok && pre_ok) begin
      add_job = !present_q[job_a];
      add_pre = !present_q[pre_a] && (pre_a != job_a || !add_job);
    end
  end

  // load second node slot lands one after the first when both added
  logic [NW-1:0] pre_slot;
  logic [1:0]    adds;
  assign pre_slot = node_cnt_q + NW'(add_job);
  assign adds     = 2'(add_job) + 2'(add_pre);

  logic [JA-1:0] v_a, u_a;
  assign v_a = pre_q[JA-1:0];
  assign u_a = u_q[JA-1:0];
  logic [JA-1:0] spm1;
  assign spm1 = JA'(sp_q - NW'(1));

  // control and mark registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= '0;
      done_q     <= '0;
      onpath_q   <= '0;
      node_cnt_q <= '0;
      edge_cnt_q <= '0;
      ovf_q      <= 1'b0;
      r_q <= '0; sp_q <= '0; n_q <= '0; op_q <= '0; e_q <= '0; clr_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (add_job && node_cnt_q < NW'(MaxJobs)) present_q[job_a] <= 1'b1;
        if (add_pre && pre_slot < NW'(MaxJobs)) present_q[pre_a] <= 1'b1;
        if (node_cnt_q + NW'(adds) > NW'(MaxJobs)) node_cnt_q <= NW'(MaxJobs);
        else node_cnt_q <= node_cnt_q + NW'(adds);
        if (is_edge && job_ok && pre_ok) begin
          if (edge_cnt_q < EW'(MaxEdges)) edge_cnt_q <= edge_cnt_q + EW'(1);
          else ovf_q <= 1'b1;
        end
      end
      if (cmd_i.run_start) begin
        r_q <= node_cnt_q; sp_q <= '0; n_q <= '0; op_q <= '0; clr_q <= '0;
      end
      if (cmd_i.root_take) r_q <= r_q - NW'(1);
      if (cmd_i.push_root) begin
        onpath_q[root_q[JA-1:0]] <= 1'b1;
        sp_q <= NW'(1);
      end
      if (cmd_i.top_rd) e_q <= sedge_mem[spm1];
      if (cmd_i.scan_step) begin
        if (e_q >= edge_cnt_q) begin
          // pop u
          sp_q <= sp_q - NW'(1);
          onpath_q[u_a] <= 1'b0;
          done_q[u_a] <= 1'b1;
          if (n_q < NW'(MaxJobs)) n_q <= n_q + NW'(1);
        end else begin
          e_q <= e_q + EW'(1);
        end
      end
      if (cmd_i.child_eval && !done_q[v_a] && !onpath_q[v_a] && sp_q < NW'(MaxJobs)) begin
        onpath_q[v_a] <= 1'b1;
        sp_q <= sp_q + NW'(1);
      end
      if (cmd_i.emit_step) op_q <= op_q + NW'(1);
      if (cmd_i.clear_step) begin
        done_q[clr_q] <= 1'b0;
        onpath_q[clr_q] <= 1'b0;
        present_q[clr_q] <= 1'b0;
        clr_q <= clr_q + JA'(1);
      end
      if (cmd_i.clear_done) begin
        node_cnt_q <= '0; edge_cnt_q <= '0; ovf_q <= 1'b0;
      end
    end
  end

  // memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (add_job && node_cnt_q < NW'(MaxJobs)) node_mem[node_cnt_q[JA-1:0]] <= in_i.job_index;
      if (add_pre && pre_slot < NW'(MaxJobs)) node_mem[pre_slot[JA-1:0]] <= in_i.prereq_index;
      if (is_edge && job_ok && pre_ok && edge_cnt_q < EW'(MaxEdges)) begin
        need_mem[edge_cnt_q[EA-1:0]] <= in_i.job_index;
        pre_mem[edge_cnt_q[EA-1:0]]  <= in_i.prereq_index;
      end
    end
    if (cmd_i.root_rd) root_q <= node_mem[JA'(r_q - NW'(1))];
    if (cmd_i.push_root) begin
      snode_mem[0] <= root_q;
      sedge_mem[0] <= '0;
    end
    if (cmd_i.top_rd) u_q <= snode_mem[spm1];
    if (cmd_i.scan_rd) begin
      need_q <= need_mem[e_q[EA-1:0]];
      pre_q  <= pre_mem[e_q[EA-1:0]];
    end
    if (cmd_i.scan_step) begin
      if (e_q >= edge_cnt_q) begin
        if (n_q < NW'(MaxJobs)) ord_mem[n_q[JA-1:0]] <= u_q;
      end else if (need_q == u_q) begin
        sedge_mem[spm1] <= e_q + EW'(1);
      end
    end
    if (cmd_i.child_eval && !done_q[v_a] && !onpath_q[v_a] && sp_q < NW'(MaxJobs)) begin
      snode_mem[sp_q[JA-1:0]] <= pre_q;
      sedge_mem[sp_q[JA-1:0]] <= '0;
    end
    if (cmd_i.emit_rd) ord_q <= ord_mem[op_q[JA-1:0]];
  end

  assign emit_job_o = ord_q;

  always_comb begin
    stat_o.r_zero      = (r_q == '0);
    stat_o.root_done   = done_q[root_q[JA-1:0]];
    stat_o.sp_zero     = (sp_q == '0);
    stat_o.edge_end    = (e_q >= edge_cnt_q);
    stat_o.edge_match  = (need_q == u_q);
    stat_o.child_done  = done_q[v_a];
    stat_o.child_cycle = onpath_q[v_a] || (sp_q >= NW'(MaxJobs));
    stat_o.emit_last   = (op_q + NW'(1) >= n_q);
    stat_o.clear_last  = (clr_q == JA'(MaxJobs - 1));
    stat_o.overflow    = ovf_q;
    stat_o.empty       = (node_cnt_q == '0);
    stat_o.n_zero      = (n_q == '0);
  end

endmodule

// ----- hw/rtl/tsd_ctrl.sv -----
// Controller state machine of the topological sort.
// Depends on tsd_pkg; sequences tsd_datapath through cmd_t and stat_t.
module tsd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_func_i,
  input  tsd_pkg::stat_t        stat_i,
  output tsd_pkg::cmd_t         cmd_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            out_status_o,
  output logic                  out_last_o,
  output logic                  out_from_buf_o
);
  tsd_pkg::ctl_state_e state_q, state_d;
  logic                ov_q, ov_d;       // output register full
  logic [1:0]          st_q, st_d;
  logic [1:0]          code_q, code_d;   // status code waiting for the output register
  logic                last_q, last_d;
  logic                buf_q, buf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsd_pkg::CtlIdle;
      ov_q    <= 1'b0;
      st_q    <= tsd_pkg::StOrdered;
      code_q  <= tsd_pkg::StOrdered;
      last_q  <= 1'b0;
      buf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      st_q    <= st_d;
      code_q  <= code_d;
      last_q  <= last_d;
      buf_q   <= buf_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_status_o   = st_q;
  assign out_last_o     = last_q;
  assign out_from_buf_o = buf_q;

  logic out_free;
  assign out_free = !ov_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ov_d       = ov_q && !out_ready_i;
    st_d       = st_q;
    code_d     = code_q;
    last_d     = last_q;
    buf_d      = buf_q;
    case (state_q)
      tsd_pkg::CtlIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == tsd_pkg::FuncRun) begin
            cmd_o.run_start = 1'b1;
            state_d = tsd_pkg::CtlRoot;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      tsd_pkg::CtlRoot: begin
        if (stat_i.overflow) begin
          code_d = tsd_pkg::StOverflow;
          state_d = tsd_pkg::CtlStatus;
        end else if (stat_i.empty) begin
          code_d = tsd_pkg::StEmpty;
          state_d = tsd_pkg::CtlStatus;
        end else if (stat_i.r_zero) begin
          if (stat_i.n_zero) begin
            code_d = tsd_pkg::StCycle;
            state_d = tsd_pkg::CtlStatus;
          end else begin
            cmd_o.emit_rd = 1'b1;
            state_d = tsd_pkg::CtlEmit;
          end
        end else begin
          cmd_o.root_rd = 1'b1;
          cmd_o.root_take = 1'b1;
          state_d = tsd_pkg::CtlRootWait;
        end
      end
      tsd_pkg::CtlRootWait: begin
        if (stat_i.root_done) begin
          state_d = tsd_pkg::CtlRoot;
        end else begin
          cmd_o.push_root = 1'b1;
          state_d = tsd_pkg::CtlTop;
        end
      end
      tsd_pkg::CtlTop: begin
        if (stat_i.sp_zero) begin
          state_d = tsd_pkg::CtlRoot;
        end else begin
          cmd_o.top_rd = 1'b1;
          state_d = tsd_pkg::CtlScan;
        end
      end
      tsd_pkg::CtlScan: begin
        cmd_o.scan_rd = 1'b1;
        state_d = tsd_pkg::CtlEdgeWait;
      end
      tsd_pkg::CtlEdgeWait: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.edge_end) state_d = tsd_pkg::CtlTop;
        else if (stat_i.edge_match) state_d = tsd_pkg::CtlChild;
        else state_d = tsd_pkg::CtlScan;
      end
      tsd_pkg::CtlChild: begin
        if (stat_i.child_done) begin
          state_d = tsd_pkg::CtlTop;
        end else if (stat_i.child_cycle) begin
          code_d = tsd_pkg::StCycle;
          state_d = tsd_pkg::CtlStatus;
        end else begin
          cmd_o.child_eval = 1'b1;
          state_d = tsd_pkg::CtlTop;
        end
      end
      tsd_pkg::CtlEmit: begin
        // ord word is registered; move it into output register
        if (out_free) begin
          ov_d   = 1'b1;
          st_d   = tsd_pkg::StOrdered;
          last_d = stat_i.emit_last;
          buf_d  = 1'b1;
          cmd_o.emit_step = 1'b1;
          if (stat_i.emit_last) state_d = tsd_pkg::CtlClear;
          else state_d = tsd_pkg::CtlRoot;
        end
      end
      tsd_pkg::CtlStatus: begin
        if (out_free) begin
          ov_d   = 1'b1;
          st_d   = code_q;
          last_d = 1'b1;
          buf_d  = 1'b0;
          state_d = tsd_pkg::CtlClear;
        end
      end
      tsd_pkg::CtlClear: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          cmd_o.clear_done = 1'b1;
          state_d = tsd_pkg::CtlIdle;
        end
      end
      default: state_d = tsd_pkg::CtlIdle;
    endcase
    // Emit loop: after each emit but the last, return through Root with r zero and n set
    if (state_q == tsd_pkg::CtlEmit && out_free && !stat_i.emit_last) begin
      state_d = tsd_pkg::CtlRoot;
    end
  end

endmodule

// ----- test/tb_topological_sort_dfs.sv -----
// Self-checking testbench for topological_sort_dfs: loads random dependency graphs,
// runs the depth-first sort and scores every output word against an in-bench predictor.
// Depends on tsd_pkg and the topological_sort_dfs RTL.
module tb_topological_sort_dfs;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumJobs  = 64;
  localparam int NumEdges = 256;
  localparam int CycleLimit = 4000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  tsd_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  tsd_pkg::out_word_t out_word_o;

  topological_sort_dfs uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o)
  );

  always #2 clk_i = ~clk_i;

  // stimulus and scoreboard storage
  tsd_pkg::in_word_t  load_q[$];
  tsd_pkg::out_word_t sorted_word_q[$];
  int        words_total;
  int        words_sent = 0;
  bit        stim_ready = 1'b0;
  bit        word_taken = 1'b0;
  int        mismatches = 0;
  int        cycles = 0;

  // predictor copy of the graph
  bit       job_seen[NumJobs];
  bit [5:0] node_list[NumJobs];
  int       node_cnt;
  bit [5:0] need_tab[NumEdges];
  bit [5:0] pre_tab[NumEdges];
  int       edge_cnt;
  bit       edges_dropped;

  function automatic void add_node(bit [5:0] j);
    if (!job_seen[j] && node_cnt < NumJobs) begin
      job_seen[j] = 1'b1;
      node_list[node_cnt] = j;
      node_cnt++;
    end
  endfunction

  function automatic void expect_status(tsd_pkg::status_e st);
    tsd_pkg::out_word_t w;
    w.job_out = '0;
    w.status  = st;
    w.last    = 1'b1;
    sorted_word_q = {sorted_word_q, w};
  endfunction

  // Depth-first walk; returns 1 on a cycle, order left in topo
  function automatic bit walk_graph(output bit [5:0] topo[NumJobs], output int n);
    bit       done_f[NumJobs];
    bit       path_f[NumJobs];
    bit [5:0] stk_node[NumJobs];
    int       stk_edge[NumJobs];
    int       r, sp, e;
    bit [5:0] u, v;
    n = 0;
    foreach (done_f[i]) begin
      done_f[i] = 1'b0;
      path_f[i] = 1'b0;
    end
    for (r = node_cnt - 1; r >= 0; r--) begin
      if (done_f[node_list[r]]) continue;
      stk_node[0] = node_list[r];
      stk_edge[0] = 0;
      sp = 1;
      path_f[node_list[r]] = 1'b1;
      while (sp > 0) begin
        u = stk_node[sp-1];
        e = stk_edge[sp-1];
        while (e < edge_cnt && need_tab[e] != u) e++;
        if (e >= edge_cnt) begin
          sp--;
          path_f[u] = 1'b0;
          done_f[u] = 1'b1;
          if (n < NumJobs) begin
            topo[n] = u;
            n++;
          end
          continue;
        end
        stk_edge[sp-1] = e + 1;
        v = pre_tab[e];
        if (done_f[v]) continue;
        if (path_f[v] || sp >= NumJobs) return 1'b1;
        path_f[v] = 1'b1;
        stk_node[sp] = v;
        stk_edge[sp] = 0;
        sp++;
      end
    end
    return 1'b0;
  endfunction

  // Apply one accepted word to the predictor
  function automatic void predict_word(tsd_pkg::in_word_t w);
    bit [5:0]           topo[NumJobs];
    int                 n;
    tsd_pkg::out_word_t o;
    case (tsd_pkg::func_e'(w.func))
      tsd_pkg::FuncDeclare: add_node(w.job_index);
      tsd_pkg::FuncEdge: begin
        add_node(w.job_index);
        add_node(w.prereq_index);
        if (edge_cnt < NumEdges) begin
          need_tab[edge_cnt] = w.job_index;
          pre_tab[edge_cnt]  = w.prereq_index;
          edge_cnt++;
        end else begin
          edges_dropped = 1'b1;
        end
      end
      tsd_pkg::FuncRun: begin
        if (edges_dropped) expect_status(tsd_pkg::StOverflow);
        else if (node_cnt == 0) expect_status(tsd_pkg::StEmpty);
        else if (walk_graph(topo, n) || n == 0) expect_status(tsd_pkg::StCycle);
        else begin
          for (int i = 0; i < n; i++) begin
            o.job_out = topo[i];
            o.status  = tsd_pkg::StOrdered;
            o.last    = (i == n - 1);
            sorted_word_q = {sorted_word_q, o};
          end
        end
        foreach (job_seen[i]) job_seen[i] = 1'b0;
        node_cnt = 0;
        edge_cnt = 0;
        edges_dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // stimulus builders
  function automatic void queue_word(tsd_pkg::func_e f, int j, int p);
    tsd_pkg::in_word_t w;
    w.func = f;
    w.job_index = j[5:0];
    w.prereq_index = p[5:0];
    load_q = {load_q, w};
  endfunction

  // Random graph over n distinct jobs; acyclic unless make_cycle is set
  function automatic void queue_graph(int n, int n_edges, bit make_cycle);
    int pool[NumJobs];
    int a, b, t;
    foreach (pool[i]) pool[i] = i;
    for (int i = NumJobs - 1; i > 0; i--) begin
      t = $urandom_range(i);
      a = pool[i];
      pool[i] = pool[t];
      pool[t] = a;
    end
    for (int i = 0; i < n_edges + n; i++) begin
      a = $urandom_range(n - 1);
      b = $urandom_range(n - 1);
      if ($urandom_range(3) == 0 || a == b)
        queue_word(tsd_pkg::FuncDeclare, pool[a], $urandom_range(63));
      else if (a < b) queue_word(tsd_pkg::FuncEdge, pool[a], pool[b]);
      else queue_word(tsd_pkg::FuncEdge, pool[b], pool[a]);
      if ($urandom_range(30) == 0)
        queue_word(tsd_pkg::FuncNone, $urandom_range(63), $urandom_range(63));
    end
    if (make_cycle) begin
      if (n < 2 || $urandom_range(4) == 0) begin
        a = pool[$urandom_range(n - 1)];
        queue_word(tsd_pkg::FuncEdge, a, a);
      end else begin
        queue_word(tsd_pkg::FuncEdge, pool[0], pool[n-1]);
        queue_word(tsd_pkg::FuncEdge, pool[n-1], pool[0]);
      end
    end
    queue_word(tsd_pkg::FuncRun, $urandom_range(63), $urandom_range(63));
  endfunction

  // Driver: new word at the falling edge once the previous one was taken
  always @(negedge clk_i) begin
    int  phase;
    bit  idle_in, idle_out;
    phase = (words_total > 0) ? (words_sent * 3) / words_total : 2;
    idle_in  = (phase == 0) ? ($urandom_range(99) < 11) :
               (phase == 1) ? ($urandom_range(99) < 88) : 1'b0;
    idle_out = (phase == 0) ? ($urandom_range(99) < 88) :
               (phase == 1) ? ($urandom_range(99) < 11) : 1'b0;
    if (rst_ni && stim_ready) begin
      out_ready_i <= !idle_out;
      if (!in_valid_i || word_taken) begin
        if (load_q.size() > 0 && !idle_in) begin
          in_word_i  <= load_q.pop_front();
          in_valid_i <= 1'b1;
          words_sent++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: accepted words feed the predictor, results are scored
  always @(posedge clk_i) begin
    tsd_pkg::out_word_t exp_w;
    word_taken = in_valid_i && in_ready_o;
    if (rst_ni && word_taken) predict_word(in_word_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_word_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word job=%0d status=%0d last=%0d",
                   out_word_o.job_out, out_word_o.status, out_word_o.last);
      end else begin
        exp_w = sorted_word_q.pop_front();
        if (exp_w.job_out !== out_word_o.job_out || exp_w.status !== out_word_o.status ||
            exp_w.last !== out_word_o.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp job=%0d st=%0d last=%0d got job=%0d st=%0d last=%0d",
                     exp_w.job_out, exp_w.status, exp_w.last,
                     out_word_o.job_out, out_word_o.status, out_word_o.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // directed: empty run, extremes, repeats, unused func, cycles
    queue_word(tsd_pkg::FuncRun, 63, 63);
    queue_word(tsd_pkg::FuncDeclare, 0, 63);
    queue_word(tsd_pkg::FuncDeclare, 63, 0);
    queue_word(tsd_pkg::FuncDeclare, 0, 0);
    queue_word(tsd_pkg::FuncEdge, 63, 0);
    queue_word(tsd_pkg::FuncNone, 63, 63);
    queue_word(tsd_pkg::FuncRun, 0, 0);
    queue_word(tsd_pkg::FuncEdge, 21, 21);
    queue_word(tsd_pkg::FuncRun, 42, 21);
    queue_word(tsd_pkg::FuncEdge, 5, 9);
    queue_word(tsd_pkg::FuncEdge, 9, 5);
    queue_word(tsd_pkg::FuncRun, 0, 0);
    queue_word(tsd_pkg::FuncNone, 0, 0);
    queue_word(tsd_pkg::FuncRun, 0, 0);
    queue_word(tsd_pkg::FuncEdge, 1, 2);
    queue_word(tsd_pkg::FuncEdge, 1, 3);
    queue_word(tsd_pkg::FuncEdge, 3, 2);
    queue_word(tsd_pkg::FuncDeclare, 42, 0);
    queue_word(tsd_pkg::FuncRun, 0, 0);
    // full edge table plus one dropped edge, then a clean run afterwards
    for (int i = 0; i < NumEdges + 1; i++) queue_word(tsd_pkg::FuncEdge, 1, 0);
    queue_word(tsd_pkg::FuncRun, 0, 0);
    queue_graph(64, 30, 1'b0);
    // random graphs, mostly small
    while (load_q.size() < 400) begin
      if ($urandom_range(9) == 0) queue_graph($urandom_range(20, 40), $urandom_range(10, 30),
                                              $urandom_range(4) == 0);
      else queue_graph($urandom_range(1, 8), $urandom_range(0, 10), $urandom_range(4) == 0);
    end
    words_total = load_q.size();
    stim_ready = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (load_q.size() == 0 && !in_valid_i && sorted_word_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && sorted_word_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
